// File: rtl/hsl_color_pair_compare_assert.svh
// Assertion macros for the HSL colour pair compare block.
// Included by the top level; relies on nothing else.
`ifndef HSL_COLOR_PAIR_COMPARE_ASSERT_SVH
`define HSL_COLOR_PAIR_COMPARE_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define HSLC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset
`define HSLC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// File: rtl/hslc_pkg.sv
// Shared types and constants for the HSL colour pair compare block.
// Used by the lane, merge and top-level files; depends on nothing.
package hslc_pkg;

    // Field widths
    localparam int CH_W    = 8;
    localparam int COL_W   = 24;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 7;
    localparam int LIGHT_W = 7;
    localparam int GAP_W   = 8;
    localparam int DIST_W  = 13;
    localparam int RGBSQ_W = 18;
    localparam int THR_W   = 13;
    localparam int HLIM_W  = 8;
    localparam int LLIM_W  = 7;
    localparam int WGT_W   = 4;
    localparam int SQ_W    = 16;
    localparam int SUM_W   = 9;

    // Divider operand widths and depth (one quotient bit per stage)
    localparam int DIV_STAGES = 7;
    localparam int SNUM_W     = 15;
    localparam int SDEN_W     = 9;
    localparam int HNUM_W     = 14;
    localparam int HDEN_W     = 8;

    // Pipeline depths
    localparam int LANE_LAT   = DIV_STAGES + 2;
    localparam int MERGE_LAT  = 3;
    localparam int PIPE_DEPTH = 1 + LANE_LAT + MERGE_LAT;
    localparam int RGB_DLY    = LANE_LAT - 1;

    // Colour-space constants
    localparam int HUE_FULL    = 360;
    localparam int HUE_HALF    = 180;
    localparam int HUE_GREEN   = 120;
    localparam int HUE_BLUE    = 240;
    localparam int SECT_SPAN   = 60;
    localparam int PCT         = 100;
    localparam int SUM_MID     = 255;
    localparam int SUM_FULL    = 510;
    // (sum*10 + 1) * 1285 >> 16 equals sum*100/510 for sums up to 510
    localparam int LIGHT_MUL   = 12850;
    localparam int LIGHT_BIAS  = 1285;
    localparam int LIGHT_SHIFT = 16;
    localparam int LPROD_W     = 23;

    // Register reset values
    localparam logic [THR_W-1:0]  RST_DIST_THR   = THR_W'(165);
    localparam logic [HLIM_W-1:0] RST_HUE_NEAR   = HLIM_W'(18);
    localparam logic [LLIM_W-1:0] RST_LIGHT_NEAR = LLIM_W'(24);
    localparam logic [WGT_W-1:0]  RST_HUE_WGT    = WGT_W'(5);
    localparam logic [WGT_W-1:0]  RST_SAT_WGT    = WGT_W'(3);
    localparam logic [WGT_W-1:0]  RST_LIGHT_WGT  = WGT_W'(4);

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_DIST_THR   = 3'd0,
        REG_HUE_NEAR   = 3'd1,
        REG_LIGHT_NEAR = 3'd2,
        REG_HUE_WGT    = 3'd3,
        REG_SAT_WGT    = 3'd4,
        REG_LIGHT_WGT  = 3'd5
    } t_reg_idx;

    // Channel holding the maximum, picks the hue base
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0]   h;
        logic [SAT_W-1:0]   s;
        logic [LIGHT_W-1:0] l;
    } t_hsl;

    typedef struct packed {
        logic [LIGHT_W-1:0] l;
        logic               grey;
        logic               neg;
        t_sector            sect;
    } t_side;

    typedef struct packed {
        logic [THR_W-1:0]  dist_thr;
        logic [HLIM_W-1:0] hue_near;
        logic [LLIM_W-1:0] light_near;
        logic [WGT_W-1:0]  hue_wgt;
        logic [WGT_W-1:0]  sat_wgt;
        logic [WGT_W-1:0]  light_wgt;
    } t_cfg;

    typedef struct packed {
        logic [RGBSQ_W-1:0] rgbsq;
        logic               same;
    } t_rgb;

    typedef struct packed {
        logic [DIST_W-1:0]  wdist;
        logic [GAP_W-1:0]   hue_gap;
        logic [RGBSQ_W-1:0] rgbsq;
        logic               similar;
        logic               same;
    } t_cmp_res;

endpackage

// File: rtl/hsl_color_pair_compare.sv
// HSL colour pair compare: top level with config registers, two lanes and merge.
// Depends on hslc_pkg, hslc_lane, hslc_merge and the assertion macro header.
//
// Usage:
//   An item is a pair of packed RGB colours (red in the low byte). It is taken
//   at a rising edge with start high and busy low; busy is always low, so a
//   new item may be taken every cycle. Both colours are converted to integer
//   HSL in two identical lanes, each built round two pipelined dividers of
//   seven stages (one quotient bit per stage); a merge stage forms the gaps,
//   the weighted distance and the similarity flag, while the squared RGB
//   distance runs alongside.
//   Throughput is one item per cycle, set by the fully pipelined dividers.
//   Each result is shown for exactly one cycle marked by o_valid; there is
//   no back-pressure, the receiver must take it then.
//   Registers are written through the APB port at byte address 4*index; the
//   user is to write them only while no item is in flight, and the block
//   itself does not enforce this. Reset (i_rst_n low, synchronous) empties
//   the pipeline and loads the register defaults; no clearing pass is needed.
`include "hsl_color_pair_compare_assert.svh"

module hsl_color_pair_compare (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           start,
    output logic                           busy,
    input  logic [hslc_pkg::COL_W-1:0]     i_color_a,
    input  logic [hslc_pkg::COL_W-1:0]     i_color_b,
    output logic                           o_valid,
    output logic [hslc_pkg::DIST_W-1:0]    o_weighted_distance,
    output logic [hslc_pkg::GAP_W-1:0]     o_hue_gap,
    output logic [hslc_pkg::RGBSQ_W-1:0]   o_rgb_square_distance,
    output logic                           o_too_similar,
    output logic                           o_identical,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hslc_pkg::PADDR_W-1:0]   paddr,
    input  logic [hslc_pkg::PDATA_W-1:0]   pwdata,
    output logic [hslc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    import hslc_pkg::*;

    t_cfg                r_cfg;
    t_reg_idx            reg_idx;
    logic                accept;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic [COL_W-1:0]    r_col_a, r_col_b;
    logic [SQ_W-1:0]     r_sq [3];
    logic                r_same;
    t_rgb                r_rgb_dly [RGB_DLY];
    logic [CH_W-1:0]     dmag [3];

    t_hsl                hsl_a, hsl_b;
    t_cmp_res            res;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign accept  = start && !busy;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dist_thr   <= RST_DIST_THR;
            r_cfg.hue_near   <= RST_HUE_NEAR;
            r_cfg.light_near <= RST_LIGHT_NEAR;
            r_cfg.hue_wgt    <= RST_HUE_WGT;
            r_cfg.sat_wgt    <= RST_SAT_WGT;
            r_cfg.light_wgt  <= RST_LIGHT_WGT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_DIST_THR:   r_cfg.dist_thr   <= pwdata[THR_W-1:0];
                REG_HUE_NEAR:   r_cfg.hue_near   <= pwdata[HLIM_W-1:0];
                REG_LIGHT_NEAR: r_cfg.light_near <= pwdata[LLIM_W-1:0];
                REG_HUE_WGT:    r_cfg.hue_wgt    <= pwdata[WGT_W-1:0];
                REG_SAT_WGT:    r_cfg.sat_wgt    <= pwdata[WGT_W-1:0];
                REG_LIGHT_WGT:  r_cfg.light_wgt  <= pwdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_DIST_THR:   prdata = PDATA_W'(r_cfg.dist_thr);
            REG_HUE_NEAR:   prdata = PDATA_W'(r_cfg.hue_near);
            REG_LIGHT_NEAR: prdata = PDATA_W'(r_cfg.light_near);
            REG_HUE_WGT:    prdata = PDATA_W'(r_cfg.hue_wgt);
            REG_SAT_WGT:    prdata = PDATA_W'(r_cfg.sat_wgt);
            REG_LIGHT_WGT:  prdata = PDATA_W'(r_cfg.light_wgt);
            default:        prdata = '0;
        endcase
    end

    // item valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], accept};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        r_col_a <= i_color_a;
        r_col_b <= i_color_b;
    end

    // per-channel absolute differences
    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign dmag[c] = (r_col_a[c*CH_W +: CH_W] >= r_col_b[c*CH_W +: CH_W])
                       ? r_col_a[c*CH_W +: CH_W] - r_col_b[c*CH_W +: CH_W]
                       : r_col_b[c*CH_W +: CH_W] - r_col_a[c*CH_W +: CH_W];
        always_ff @(posedge i_clk) begin
            r_sq[c] <= SQ_W'(dmag[c]) * SQ_W'(dmag[c]);
        end
    end

    // squared RGB distance and equality, delayed to meet the lanes
    always_ff @(posedge i_clk) begin
        r_same             <= (r_col_a == r_col_b);
        r_rgb_dly[0].rgbsq <= RGBSQ_W'(r_sq[0]) + RGBSQ_W'(r_sq[1]) + RGBSQ_W'(r_sq[2]);
        r_rgb_dly[0].same  <= r_same;
    end

    for (genvar k = 1; k < RGB_DLY; k++) begin : g_rgb_dly
        always_ff @(posedge i_clk) begin
            r_rgb_dly[k] <= r_rgb_dly[k-1];
        end
    end

    // conversion lanes
    hslc_lane u_lane_a (
        .i_clk   (i_clk),
        .i_color (r_col_a),
        .o_hsl   (hsl_a)
    );

    hslc_lane u_lane_b (
        .i_clk   (i_clk),
        .i_color (r_col_b),
        .o_hsl   (hsl_b)
    );

    hslc_merge u_merge (
        .i_clk   (i_clk),
        .i_hsl_a (hsl_a),
        .i_hsl_b (hsl_b),
        .i_rgb   (r_rgb_dly[RGB_DLY-1]),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result ports
    assign o_valid               = r_vld[PIPE_DEPTH-1];
    assign o_weighted_distance   = res.wdist;
    assign o_hue_gap             = res.hue_gap;
    assign o_rgb_square_distance = res.rgbsq;
    assign o_too_similar         = res.similar;
    assign o_identical           = res.same;

    // checks
    `HSLC_ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_valid, $past(accept, PIPE_DEPTH), "result without an item taken 13 cycles earlier")
    `HSLC_ASSERT_IMPL(a_same_similar, i_clk, i_rst_n, o_valid && o_identical, o_too_similar, "identical pair not flagged too similar")
    `HSLC_ASSERT_IMPL(a_same_zero, i_clk, i_rst_n, o_valid && o_identical, (o_rgb_square_distance == '0) && (o_hue_gap == '0) && (o_weighted_distance == '0), "identical pair with non-zero distance")
    `HSLC_ASSERT_NEVER(a_hue_fold, i_clk, i_rst_n, o_valid && (o_hue_gap > GAP_W'(HUE_HALF)), "hue gap not folded")

endmodule

// File: rtl/hslc_div.sv
// Pipelined restoring divider, one quotient bit per stage, QW stages deep.
// Stand-alone; the caller guarantees num < den * 2**QW.
module hslc_div #(
    parameter int NW = 15,
    parameter int DW = 9,
    parameter int QW = 7
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int CW = NW + DW;

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    genvar s;
    for (s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] sub_w;
        logic [CW-1:0] diff_w;
        logic          ge;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            sub_w    = CW'(den_in) << K;
            ge       = CW'(rem_in) >= sub_w;
            diff_w   = CW'(rem_in) - sub_w;
            n_quo    = quo_in;
            n_quo[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            r_quo[s] <= n_quo;
        end

        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= ge ? diff_w[NW-1:0] : rem_in;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// File: rtl/hslc_lane.sv
// One conversion lane: packed RGB colour to integer HSL.
// Depends on hslc_pkg and two hslc_div instances.
module hslc_lane (
    input  logic                        i_clk,
    input  logic [hslc_pkg::COL_W-1:0]  i_color,
    output hslc_pkg::t_hsl              o_hsl
);

    import hslc_pkg::*;

    logic [CH_W-1:0]    red, grn, blu, hi, lo, delta, hmag;
    logic [SUM_W-1:0]   sum, hdiff;
    logic [SDEN_W-1:0]  sden;
    logic [LPROD_W-1:0] lprod;
    t_sector            sect;
    t_side              n_side;

    logic [SNUM_W-1:0]  r_snum;
    logic [SDEN_W-1:0]  r_sden;
    logic [HNUM_W-1:0]  r_hnum;
    logic [HDEN_W-1:0]  r_hden;
    t_side              r_side [DIV_STAGES+1];

    logic [DIV_STAGES-1:0] squo, hquo;
    logic [HUE_W-1:0]      q9, n_h;
    t_side                 last;
    t_hsl                  r_hsl;

    // extremes, lightness, saturation divisor and hue numerator
    always_comb begin
        red = i_color[CH_W-1:0];
        grn = i_color[2*CH_W-1:CH_W];
        blu = i_color[3*CH_W-1:2*CH_W];
        hi  = (red > grn) ? red : grn;
        lo  = (red < grn) ? red : grn;
        if (blu > hi) hi = blu;
        if (blu < lo) lo = blu;
        delta = hi - lo;
        sum   = SUM_W'(hi) + SUM_W'(lo);
        sden  = (sum < SUM_W'(SUM_MID)) ? sum : SUM_W'(SUM_FULL) - sum;
        if (sden == '0) sden = SDEN_W'(1);
        lprod = LPROD_W'(sum) * LPROD_W'(LIGHT_MUL) + LPROD_W'(LIGHT_BIAS);
        if (hi == red) begin
            sect  = SECT_RED;
            hdiff = SUM_W'(grn) - SUM_W'(blu);
        end else if (hi == grn) begin
            sect  = SECT_GREEN;
            hdiff = SUM_W'(blu) - SUM_W'(red);
        end else begin
            sect  = SECT_BLUE;
            hdiff = SUM_W'(red) - SUM_W'(grn);
        end
        hmag        = hdiff[SUM_W-1] ? CH_W'(-hdiff) : hdiff[CH_W-1:0];
        n_side.l    = lprod[LIGHT_SHIFT +: LIGHT_W];
        n_side.grey = (delta == '0);
        n_side.neg  = hdiff[SUM_W-1];
        n_side.sect = sect;
    end

    // operand register ahead of the dividers
    always_ff @(posedge i_clk) begin
        r_snum    <= SNUM_W'(delta) * SNUM_W'(PCT);
        r_sden    <= sden;
        r_hnum    <= HNUM_W'(hmag) * HNUM_W'(SECT_SPAN);
        r_hden    <= delta;
        r_side[0] <= n_side;
    end

    hslc_div #(.NW(SNUM_W), .DW(SDEN_W), .QW(DIV_STAGES)) u_sat_div (
        .i_clk (i_clk),
        .i_num (r_snum),
        .i_den (r_sden),
        .o_quo (squo)
    );

    hslc_div #(.NW(HNUM_W), .DW(HDEN_W), .QW(DIV_STAGES)) u_hue_div (
        .i_clk (i_clk),
        .i_num (r_hnum),
        .i_den (r_hden),
        .o_quo (hquo)
    );

    // side information follows the dividers
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // hue from sector base and signed quotient, wrapped into 0..359
    always_comb begin
        last = r_side[DIV_STAGES];
        q9   = HUE_W'(hquo);
        case (last.sect)
            SECT_RED: begin
                if (!last.neg) n_h = q9;
                else if (q9 == '0) n_h = '0;
                else n_h = HUE_W'(HUE_FULL) - q9;
            end
            SECT_GREEN: n_h = last.neg ? HUE_W'(HUE_GREEN) - q9 : HUE_W'(HUE_GREEN) + q9;
            SECT_BLUE:  n_h = last.neg ? HUE_W'(HUE_BLUE) - q9 : HUE_W'(HUE_BLUE) + q9;
            default:    n_h = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hsl.h <= last.grey ? '0 : n_h;
        r_hsl.s <= last.grey ? '0 : squo;
        r_hsl.l <= last.l;
    end

    assign o_hsl = r_hsl;

endmodule

// File: rtl/hslc_merge.sv
// Merging stage: HSL gaps, weighted distance and similarity decision.
// Depends on hslc_pkg; fed by two hslc_lane outputs and the RGB path.
module hslc_merge (
    input  logic                          i_clk,
    input  hslc_pkg::t_hsl                i_hsl_a,
    input  hslc_pkg::t_hsl                i_hsl_b,
    input  hslc_pkg::t_rgb                i_rgb,
    input  hslc_pkg::t_cfg                i_cfg,
    output hslc_pkg::t_cmp_res            o_res
);

    import hslc_pkg::*;

    logic [HUE_W-1:0]   hd;
    logic [GAP_W-1:0]   r1_hue;
    logic [SAT_W-1:0]   r1_sat;
    logic [LIGHT_W-1:0] r1_light;
    t_rgb               r1_rgb;

    logic [DIST_W-1:0]  r2_dist;
    logic [GAP_W-1:0]   r2_hue;
    logic               r2_near;
    t_rgb               r2_rgb;

    t_cmp_res           r_res;

    // circular hue gap and absolute saturation / lightness gaps
    always_comb begin
        hd = (i_hsl_a.h >= i_hsl_b.h) ? i_hsl_a.h - i_hsl_b.h : i_hsl_b.h - i_hsl_a.h;
    end

    always_ff @(posedge i_clk) begin
        r1_hue   <= (hd > HUE_W'(HUE_HALF)) ? GAP_W'(HUE_W'(HUE_FULL) - hd) : hd[GAP_W-1:0];
        r1_sat   <= (i_hsl_a.s >= i_hsl_b.s) ? i_hsl_a.s - i_hsl_b.s : i_hsl_b.s - i_hsl_a.s;
        r1_light <= (i_hsl_a.l >= i_hsl_b.l) ? i_hsl_a.l - i_hsl_b.l : i_hsl_b.l - i_hsl_a.l;
        r1_rgb   <= i_rgb;
    end

    // weighted sum and near test
    always_ff @(posedge i_clk) begin
        r2_dist <= DIST_W'(r1_hue) * DIST_W'(i_cfg.hue_wgt)
                 + DIST_W'(r1_sat) * DIST_W'(i_cfg.sat_wgt)
                 + DIST_W'(r1_light) * DIST_W'(i_cfg.light_wgt);
        r2_near <= (r1_hue < i_cfg.hue_near) && (r1_light < i_cfg.light_near);
        r2_hue  <= r1_hue;
        r2_rgb  <= r1_rgb;
    end

    // final decision
    always_ff @(posedge i_clk) begin
        r_res.wdist   <= r2_dist;
        r_res.hue_gap <= r2_hue;
        r_res.rgbsq   <= r2_rgb.rgbsq;
        r_res.same    <= r2_rgb.same;
        r_res.similar <= r2_rgb.same || r2_near || (r2_dist < i_cfg.dist_thr);
    end

    assign o_res = r_res;

endmodule
